@@ design/ipv4_header_checker_assert.svh @@
// Assertion macros for the IPv4 header checker.
// Used by the port checker; needs nothing else.
`ifndef IPV4_HEADER_CHECKER_ASSERT_SVH
`define IPV4_HEADER_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define IHC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipv4_header_checker: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define IHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipv4_header_checker: assertion failed");

`endif

@@ design/ihc_pkg.sv @@
// Shared types, constants and helper functions for the IPv4 header checker.
// No dependencies.
package ihc_pkg;

   typedef enum logic [2:0] {
      ST_ACCEPT      = 3'd0,
      ST_BAD_CSUM    = 3'd1,
      ST_BAD_VERSION = 3'd2,
      ST_FRAGMENT    = 3'd3,
      ST_LENGTH      = 3'd4
   } status_type;

   localparam logic [4:0]  IDX_VER_IHL  = 5'd0;
   localparam logic [4:0]  IDX_FRAG     = 5'd3;
   localparam logic [4:0]  IDX_TTL_PROT = 5'd4;
   localparam logic [4:0]  IDX_CSUM     = 5'd5;

   localparam logic [15:0] WORD_MASK        = 16'hffff;
   localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1fff;
   localparam logic [15:0] MORE_FRAGS_BIT   = 16'h2000;
   localparam logic [3:0]  IPV4_VERSION     = 4'd4;
   localparam logic [3:0]  MIN_IHL          = 4'd5;

   // Header-done queue between front and back; depth is a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [15:0] running_sum;
      logic [15:0] forward_sum;
      logic [4:0]  word_count;
      logic [7:0]  version_ihl;
      logic [7:0]  ttl;
      logic [7:0]  protocol;
      logic [15:0] fragment_word;
      logic        csum_zero;
   } hdr_rec_type;

   function automatic logic [15:0] oc_add(logic [15:0] acc, logic [15:0] w);
      logic [16:0] s;
      s = {1'b0, acc} + {1'b0, w};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic logic [7:0] ttl_dec(logic [7:0] t);
      return (t == 8'd0) ? 8'd0 : t - 8'd1;
   endfunction

endpackage

@@ design/ihc_front.sv @@
// Front end: takes header words, keeps both ones'-complement sums and latches fields.
// Pushes one header record per last word. Depends on ihc_pkg.
module ihc_front import ihc_pkg::*; #(
   parameter int MAX_HEADER_WORDS = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [15:0] word,
   input  logic        last,
   output logic        rec_push,
   output hdr_rec_type rec
);

   localparam logic [4:0] CNT_LIMIT = 5'(MAX_HEADER_WORDS + 1);

   logic [15:0] run_sum_ff, run_sum_in;
   logic [15:0] fwd_sum_ff, fwd_sum_in;
   logic [4:0]  count_ff, count_in;
   logic [7:0]  vihl_ff, vihl_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  prot_ff, prot_in;
   logic [15:0] frag_ff, frag_in;
   logic        czero_ff, czero_in;
   logic [15:0] fwd_word;

   always_comb begin
      vihl_in  = vihl_ff;
      ttl_in   = ttl_ff;
      prot_in  = prot_ff;
      frag_in  = frag_ff;
      czero_in = czero_ff;
      fwd_word = word;
      if (count_ff == IDX_VER_IHL) begin
         vihl_in = word[15:8];
      end else if (count_ff == IDX_FRAG) begin
         frag_in = word;
      end else if (count_ff == IDX_TTL_PROT) begin
         ttl_in   = word[15:8];
         prot_in  = word[7:0];
         fwd_word = {ttl_dec(word[15:8]), word[7:0]};
      end else if (count_ff == IDX_CSUM) begin
         czero_in = (word == 16'd0);
         fwd_word = 16'd0;
      end
      run_sum_in = oc_add(run_sum_ff, word);
      fwd_sum_in = oc_add(fwd_sum_ff, fwd_word);
      count_in   = (count_ff < CNT_LIMIT) ? count_ff + 5'd1 : count_ff;
   end

   assign rec_push          = take && last;
   assign rec.running_sum   = run_sum_in;
   assign rec.forward_sum   = fwd_sum_in;
   assign rec.word_count    = count_in;
   assign rec.version_ihl   = vihl_in;
   assign rec.ttl           = ttl_in;
   assign rec.protocol      = prot_in;
   assign rec.fragment_word = frag_in;
   assign rec.csum_zero     = czero_in;

   always_ff @(posedge clock) begin
      if (reset || (take && last)) begin
         run_sum_ff <= '0;
         fwd_sum_ff <= '0;
         count_ff   <= '0;
         vihl_ff    <= '0;
         ttl_ff     <= '0;
         prot_ff    <= '0;
         frag_ff    <= '0;
         czero_ff   <= 1'b0;
      end else if (take) begin
         run_sum_ff <= run_sum_in;
         fwd_sum_ff <= fwd_sum_in;
         count_ff   <= count_in;
         vihl_ff    <= vihl_in;
         ttl_ff     <= ttl_in;
         prot_ff    <= prot_in;
         frag_ff    <= frag_in;
         czero_ff   <= czero_in;
      end
   end

endmodule

@@ design/ihc_queue.sv @@
// Short record queue between the front end and the verdict stage.
// Depends on ihc_pkg.
module ihc_queue import ihc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  hdr_rec_type push_rec,
   output logic        full,
   input  logic        pop,
   output logic        empty,
   output hdr_rec_type head
);

   hdr_rec_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

@@ design/ihc_back.sv @@
// Back end: turns a header record into a verdict and forwarding fields.
// Holds the result register seen on the rsp_ ports. Depends on ihc_pkg.
module ihc_back import ihc_pkg::*; #(
   parameter int PROTO_SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  hdr_rec_type q_head,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic        rsp_ttl_expired,
   output logic [7:0]  rsp_forward_ttl,
   output logic [15:0] rsp_forward_checksum,
   output logic [7:0]  rsp_protocol_number,
   output logic [4:0]  rsp_protocol_slot
);

   logic        valid_ff;
   status_type  status_ff, status_in;
   logic        expired_ff;
   logic [7:0]  fttl_ff;
   logic [15:0] fcsum_ff;
   logic [7:0]  prot_ff;
   logic [4:0]  slot_ff;
   logic [4:0]  slot_lut [256];
   logic [3:0]  ihl;
   logic [3:0]  version;

   // Protocol-to-slot map, a constant table fixed at elaboration.
   for (genvar g = 0; g < 256; g++) begin : g_slot_lut
      assign slot_lut[g] = 5'(g % PROTO_SLOTS);
   end

   assign ihl       = q_head.version_ihl[3:0];
   assign version   = q_head.version_ihl[7:4];
   assign q_pop     = !q_empty && (!valid_ff || rsp_pop);

   always_comb begin
      if (ihl < MIN_IHL || q_head.word_count != {ihl, 1'b0}) begin
         status_in = ST_LENGTH;
      end else if (!q_head.csum_zero && q_head.running_sum != WORD_MASK) begin
         status_in = ST_BAD_CSUM;
      end else if (version != IPV4_VERSION) begin
         status_in = ST_BAD_VERSION;
      end else if ((q_head.fragment_word & (MORE_FRAGS_BIT | FRAG_OFFSET_MASK)) != 16'd0) begin
         status_in = ST_FRAGMENT;
      end else begin
         status_in = ST_ACCEPT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff  <= status_in;
         expired_ff <= (q_head.ttl <= 8'd1);
         fttl_ff    <= ttl_dec(q_head.ttl);
         fcsum_ff   <= ~q_head.forward_sum;
         prot_ff    <= q_head.protocol;
         slot_ff    <= slot_lut[q_head.protocol];
      end
   end

   assign rsp_empty            = !valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_ttl_expired      = expired_ff;
   assign rsp_forward_ttl      = fttl_ff;
   assign rsp_forward_checksum = fcsum_ff;
   assign rsp_protocol_number  = prot_ff;
   assign rsp_protocol_slot    = slot_ff;

endmodule

@@ design/ipv4_header_checker.sv @@
// IPv4 header checker, top level.
// Depends on ihc_pkg, ihc_front, ihc_queue and ihc_back.
//
// Input: one 16-bit network-order header word per transfer (req_push while
// req_full is low), req_last_word marking the final word of a header.
// Output: one verdict per header, shown while rsp_empty is low and taken
// with rsp_pop: status, TTL expiry, decremented TTL, recomputed checksum,
// protocol number and its dispatch slot.
// Throughput: one word per cycle while req_full is low, headers back to
// back. A verdict goes from the edge that takes its last word into a queue
// entry, then the result register once that register is free or popped.
// A two-entry record queue sits between the word accumulator and the result
// register, so words keep flowing while a verdict waits; once the queue
// fills, req_full rises until the receiver pops.
// Reset clears the sums, field latches, queue and the result register's valid
// flag; the block takes words in the first cycle after reset.
module ipv4_header_checker import ihc_pkg::*; #(
   parameter int PROTO_SLOTS      = 32,
   parameter int MAX_HEADER_WORDS = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_header_word,
   input  logic        req_last_word,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic        rsp_ttl_expired,
   output logic [7:0]  rsp_forward_ttl,
   output logic [15:0] rsp_forward_checksum,
   output logic [7:0]  rsp_protocol_number,
   output logic [4:0]  rsp_protocol_slot
);

   logic        take;
   logic        rec_push;
   hdr_rec_type rec;
   logic        q_full;
   logic        q_empty;
   logic        q_pop;
   hdr_rec_type q_head;

   assign req_full = q_full;
   assign take     = req_push && !q_full;

   ihc_front #(
      .MAX_HEADER_WORDS(MAX_HEADER_WORDS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .word     (req_header_word),
      .last     (req_last_word),
      .rec_push (rec_push),
      .rec      (rec)
   );

   ihc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_rec (rec),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   ihc_back #(
      .PROTO_SLOTS(PROTO_SLOTS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_head               (q_head),
      .q_pop                (q_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_status           (rsp_status),
      .rsp_ttl_expired      (rsp_ttl_expired),
      .rsp_forward_ttl      (rsp_forward_ttl),
      .rsp_forward_checksum (rsp_forward_checksum),
      .rsp_protocol_number  (rsp_protocol_number),
      .rsp_protocol_slot    (rsp_protocol_slot)
   );

endmodule

@@ design/ihc_checker.sv @@
// Port-level checks for the IPv4 header checker, bound to the top level.
// Depends on ipv4_header_checker_assert.svh.
`include "ipv4_header_checker_assert.svh"

module ihc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [2:0]  rsp_status,
   input logic        rsp_ttl_expired,
   input logic [7:0]  rsp_forward_ttl,
   input logic [15:0] rsp_forward_checksum
);

   // Out of reset: nothing to deliver, ready for words.
   `IHC_ASSERT_IMPLIES(a_reset_idle, clock, reset, $past(reset), rsp_empty && !req_full)

   // A waiting verdict stays put until popped.
   `IHC_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_status) && $stable(rsp_forward_checksum))

   // Expiry and decremented TTL agree.
   `IHC_ASSERT_IMPLIES(a_ttl_match, clock, reset, !rsp_empty, rsp_ttl_expired == (rsp_forward_ttl == 8'd0))

endmodule

bind ipv4_header_checker ihc_checker u_checker (.*);

@@ test/tb_ipv4_header_checker.sv @@
// Self-checking testbench for ipv4_header_checker: headers in, one verdict out per header.
// Verdicts are predicted from the accepted words and compared with every popped verdict.
// Depends on ihc_pkg and the design files.
module tb_ipv4_header_checker;
   import ihc_pkg::*;

   localparam int PROTO_SLOTS      = 32;
   localparam int MAX_HEADER_WORDS = 30;
   localparam int CALM_WORDS       = 200;

   typedef struct {
      logic [15:0] word;
      logic        last;
      bit          drain_first;
   } word_item_type;

   typedef struct {
      status_type  status;
      logic        ttl_expired;
      logic [7:0]  fwd_ttl;
      logic [15:0] fwd_csum;
      logic [7:0]  proto;
      logic [4:0]  slot;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [15:0] req_header_word = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_ttl_expired;
   logic [7:0]  rsp_forward_ttl;
   logic [15:0] rsp_forward_checksum;
   logic [7:0]  rsp_protocol_number;
   logic [4:0]  rsp_protocol_slot;

   ipv4_header_checker #(
      .PROTO_SLOTS     (PROTO_SLOTS),
      .MAX_HEADER_WORDS(MAX_HEADER_WORDS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_header_word     (req_header_word),
      .req_last_word       (req_last_word),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_status          (rsp_status),
      .rsp_ttl_expired     (rsp_ttl_expired),
      .rsp_forward_ttl     (rsp_forward_ttl),
      .rsp_forward_checksum(rsp_forward_checksum),
      .rsp_protocol_number (rsp_protocol_number),
      .rsp_protocol_slot   (rsp_protocol_slot)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   word_item_type pending_words[$];
   verdict_type   verdicts_due[$];

   // predictor state
   logic [15:0] hdr_sum;
   logic [15:0] fwd_sum;
   logic [4:0]  words_in;
   logic [7:0]  ver_ihl_latch;
   logic [7:0]  ttl_latch;
   logic [7:0]  proto_latch;
   logic [15:0] frag_latch;
   logic        csum_was_zero;

   int  mismatches = 0;
   int  headers_built = 0;
   int  words_sent = 0;
   int  verdicts_checked = 0;
   int  drains_done = 0;
   int  status_count[5] = '{default: 0};
   bit  word_taken = 0;
   bit  long_hold_done = 0;
   int  hold_left = 0;
   int  send_gap = 0, recv_gap = 0;
   int  send_odds = 0, recv_odds = 0;
   int  send_window = 0, recv_window = 0;
   logic push_next, pop_next;

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      int unsigned t;
      t = int'(a) + int'(b);
      t = (t & 32'hffff) + (t >> 16);
      return t[15:0];
   endfunction

   function automatic logic [7:0] ttl_after_hop(input logic [7:0] t);
      return (t == 8'd0) ? 8'd0 : t - 8'd1;
   endfunction

   function automatic int pick_odds();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 2;
         default: return 7;
      endcase
   endfunction

   task automatic clear_header();
      hdr_sum = '0;
      fwd_sum = '0;
      words_in = '0;
      ver_ihl_latch = '0;
      ttl_latch = '0;
      proto_latch = '0;
      frag_latch = '0;
      csum_was_zero = 1'b0;
   endtask

   task automatic take_word(input logic [15:0] w, input logic last);
      logic [15:0] fw;
      int          ihl;
      verdict_type v;
      fw = w;
      case (words_in)
         IDX_VER_IHL: ver_ihl_latch = w[15:8];
         IDX_FRAG: frag_latch = w;
         IDX_TTL_PROT: begin
            ttl_latch = w[15:8];
            proto_latch = w[7:0];
            fw = {ttl_after_hop(w[15:8]), w[7:0]};
         end
         IDX_CSUM: begin
            csum_was_zero = (w == 16'd0);
            fw = '0;
         end
         default: ;
      endcase
      hdr_sum = ones_add(hdr_sum, w);
      fwd_sum = ones_add(fwd_sum, fw);
      if (words_in < MAX_HEADER_WORDS + 1)
         words_in = words_in + 5'd1;
      if (last) begin
         ihl = ver_ihl_latch[3:0];
         if (ihl < MIN_IHL || int'(words_in) != ihl * 2)
            v.status = ST_LENGTH;
         else if (!csum_was_zero && hdr_sum != WORD_MASK)
            v.status = ST_BAD_CSUM;
         else if (ver_ihl_latch[7:4] != IPV4_VERSION)
            v.status = ST_BAD_VERSION;
         else if ((frag_latch & (MORE_FRAGS_BIT | FRAG_OFFSET_MASK)) != 16'd0)
            v.status = ST_FRAGMENT;
         else
            v.status = ST_ACCEPT;
         v.ttl_expired = (ttl_latch <= 8'd1);
         v.fwd_ttl = ttl_after_hop(ttl_latch);
         v.fwd_csum = ~fwd_sum;
         v.proto = proto_latch;
         v.slot = 5'(int'(proto_latch) % PROTO_SLOTS);
         verdicts_due.push_back(v);
         clear_header();
      end
   endtask

   // csum_mode: 0 correct, 1 zero (unchecked), 2 random
   task automatic add_header(input int n, input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [15:0] frag, input logic [7:0] ttl,
                             input logic [7:0] proto, input int csum_mode,
                             input bit drain_first);
      logic [15:0]   hw[48];
      logic [15:0]   s;
      word_item_type it;
      for (int i = 0; i < 48; i++)
         hw[i] = 16'($urandom);
      hw[0] = {ver, ihl, hw[0][7:0]};
      hw[3] = frag;
      hw[4] = {ttl, proto};
      hw[5] = '0;
      if (csum_mode == 0) begin
         s = '0;
         for (int i = 0; i < n; i++)
            s = ones_add(s, hw[i]);
         hw[5] = ~s;
      end else if (csum_mode == 2) begin
         hw[5] = 16'($urandom);
      end
      for (int i = 0; i < n; i++) begin
         it.word = hw[i];
         it.last = (i == n - 1);
         it.drain_first = drain_first && (i == 0);
         pending_words.push_back(it);
      end
      headers_built++;
   endtask

   task automatic add_random_header(input bit drain_first);
      int          r, n, mode;
      logic [3:0]  ver, ihl;
      logic [15:0] frag;
      logic [7:0]  ttl;
      r = $urandom_range(0, 99);
      ver = ($urandom_range(0, 9) == 0) ? 4'($urandom) : IPV4_VERSION;
      ihl = ($urandom_range(0, 9) < 7) ? MIN_IHL : 4'($urandom_range(6, 15));
      case ($urandom_range(0, 5))
         0, 1: frag = '0;
         2: frag = 16'h4000;
         3: frag = MORE_FRAGS_BIT | (16'($urandom) & 16'hc000);
         4: frag = 16'($urandom_range(1, 16'h1fff));
         default: frag = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0: ttl = 8'd0;
         1: ttl = 8'd1;
         2: ttl = 8'd2;
         3: ttl = 8'd255;
         default: ttl = 8'($urandom);
      endcase
      r = $urandom_range(0, 9);
      mode = (r < 7) ? 0 : (r < 8) ? 1 : 2;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         n = ihl * 2;
      end else if (r < 90) begin
         n = $urandom_range(1, 24);
      end else if (r < 95) begin
         ihl = 4'($urandom_range(0, 4));
         n = (ihl == 0) ? 1 : ihl * 2;
      end else begin
         n = $urandom_range(32, 40);
      end
      add_header(n, ver, ihl, frag, ttl, 8'($urandom), mode, drain_first);
   endtask

   // input side: offer words at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (word_taken) begin
            void'(pending_words.pop_front());
            word_taken = 0;
            words_sent++;
         end
         if (++send_window == 80) begin
            send_window = 0;
            send_odds = pick_odds();
         end
         if (send_gap == 0 && pending_words.size() > CALM_WORDS &&
             $urandom_range(0, 31) < send_odds)
            send_gap = $urandom_range(1, 10);
         push_next = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_words.size() > 0) begin
            if (pending_words[0].drain_first && verdicts_due.size() == 0) begin
               pending_words[0].drain_first = 1'b0;
               drains_done++;
            end
            if (!pending_words[0].drain_first) begin
               push_next = 1'b1;
               req_header_word <= pending_words[0].word;
               req_last_word <= pending_words[0].last;
            end
         end
         req_push <= push_next;
      end
   end

   // input transfers feed the predictor
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         take_word(req_header_word, req_last_word);
         word_taken = 1;
      end
   end

   // result side: pop with random stalls and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (!long_hold_done && verdicts_checked >= 30) begin
            long_hold_done = 1;
            hold_left = 300;
         end
         if (++recv_window == 64) begin
            recv_window = 0;
            recv_odds = pick_odds();
         end
         if (recv_gap == 0 && pending_words.size() > CALM_WORDS &&
             $urandom_range(0, 31) < recv_odds)
            recv_gap = $urandom_range(1, 10);
         pop_next = 1'b0;
         if (hold_left > 0)
            hold_left--;
         else if (recv_gap > 0)
            recv_gap--;
         else
            pop_next = 1'b1;
         rsp_pop <= pop_next;
      end
   end

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned got_val);
      if (exp_val != got_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (verdicts_due.size() == 0) begin
            $error("verdict transfer with none expected");
            mismatches++;
         end else begin
            v = verdicts_due.pop_front();
            check_field("status", v.status, rsp_status);
            check_field("ttl_expired", v.ttl_expired, rsp_ttl_expired);
            check_field("forward_ttl", v.fwd_ttl, rsp_forward_ttl);
            check_field("forward_checksum", v.fwd_csum, rsp_forward_checksum);
            check_field("protocol_number", v.proto, rsp_protocol_number);
            check_field("protocol_slot", v.slot, rsp_protocol_slot);
            status_count[v.status]++;
            verdicts_checked++;
         end
      end
   end

   initial begin
      clear_header();
      // good header, TTL about to expire, top protocol number
      add_header(10, IPV4_VERSION, MIN_IHL, 16'h0000, 8'd1, 8'd255, 0, 0);
      // single-word headers: version and IHL all ones, then all zeros
      add_header(1, 4'hf, 4'hf, 16'h0000, 8'd0, 8'd0, 1, 0);
      add_header(1, 4'h0, 4'h0, 16'h0000, 8'd0, 8'd0, 1, 0);
      // wrong version, unchecked checksum, TTL zero, MF with offset
      add_header(10, 4'd6, MIN_IHL, 16'hffff, 8'd0, 8'd6, 1, 0);
      while (pending_words.size() < 1550)
         add_random_header(headers_built == 60 || headers_built == 130);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0)
         @(posedge clock);
      while (verdicts_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d headers, %0d words, %0d verdicts, %0d drain pauses",
               headers_built, words_sent, verdicts_checked, drains_done);
      $display("verdicts: accept %0d, checksum %0d, version %0d, fragment %0d, length %0d",
               status_count[0], status_count[1], status_count[2], status_count[3],
               status_count[4]);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2400000;
      $display("timeout with %0d words pending, %0d verdicts due",
               pending_words.size(), verdicts_due.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/ihc_pkg.sv
design/ihc_front.sv
design/ihc_queue.sv
design/ihc_back.sv
design/ipv4_header_checker.sv
design/ihc_checker.sv
test/tb_ipv4_header_checker.sv
